// ----- rtl/leader_color_clustering_halfbrite_unit_defines.svh -----
// Assertion helpers for the clustering unit.
`ifndef LEADER_COLOR_CLUSTERING_HALFBRITE_UNIT_DEFINES_SVH
`define LEADER_COLOR_CLUSTERING_HALFBRITE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LCCH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lcch assertion failed");
`define LCCH_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("lcch assertion failed");
`else
`define LCCH_ASSERT(lbl, prop)
`define LCCH_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// ----- rtl/lcch_pkg.sv -----
`default_nettype none
package lcch_pkg;
  localparam int MAX_CL   = 32;
  localparam int IDX_W    = 5;
  localparam int TOT_W    = 6;
  localparam int FRAC     = 8;
  localparam int COL_W    = 8;
  localparam int MEAN_W   = 17;
  localparam int CNT_W    = 16;
  localparam int THR_W    = 18;
  localparam int SQ_W     = 34;
  localparam int ACC_W    = 36;
  localparam int DVD_W    = 34;
  localparam int DIV_CW   = 6;
  localparam int ENT_W    = 3 * MEAN_W + CNT_W + 1;
  localparam logic [DIV_CW-1:0] DIV_LAST = 6'd33;
  localparam logic [CNT_W-1:0]  CNT_MAX  = 16'hFFFF;

  localparam logic [2:0] OC_DIRECT = 3'd0;
  localparam logic [2:0] OC_HB     = 3'd1;
  localparam logic [2:0] OC_NEW    = 3'd2;
  localparam logic [2:0] OC_FULL   = 3'd3;
  localparam logic [2:0] OC_CLEAR  = 3'd4;

  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic              hb;
    logic [CNT_W-1:0]  cnt;
    logic [MEAN_W-1:0] b;
    logic [MEAN_W-1:0] g;
    logic [MEAN_W-1:0] r;
  } entry_t;

  typedef struct packed {
    logic       item_ld;
    logic       clear;
    logic       k_inc;
    logic       sq_en;
    logic       acc_clr;
    logic       acc_en;
    logic [1:0] ch;
    logic       hb_set;
    logic       mul_ld;
    logic       div_step;
    logic       wr_fold;
    logic       wr_new;
    logic       out_ld;
    logic [2:0] outcome;
  } ctl_t;

  typedef struct packed {
    logic is_clear;
    logic total_zero;
    logic full;
    logic last;
    logic match_d;
    logic match_h;
  } stat_t;
endpackage
`default_nettype wire

// ----- rtl/lcch_if.sv -----
`default_nettype none
interface lcch_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [lcch_pkg::COL_W-1:0] red;
  logic [lcch_pkg::COL_W-1:0] green;
  logic [lcch_pkg::COL_W-1:0] blue;
  modport source (output valid, cmd, red, green, blue, input ready);
  modport sink (input valid, cmd, red, green, blue, output ready);
endinterface

interface lcch_out_if;
  logic                        valid;
  logic                        ready;
  logic [lcch_pkg::IDX_W-1:0]  cluster_id;
  logic [2:0]                  outcome;
  logic [lcch_pkg::MEAN_W-1:0] mean_red;
  logic [lcch_pkg::MEAN_W-1:0] mean_green;
  logic [lcch_pkg::MEAN_W-1:0] mean_blue;
  modport source (output valid, cluster_id, outcome, mean_red, mean_green, mean_blue,
                  input ready);
  modport sink (input valid, cluster_id, outcome, mean_red, mean_green, mean_blue,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/leader_color_clustering_halfbrite_unit.sv -----
// Sequence: a clear goes from decode straight to the output; otherwise every cluster
// scanned passes read, square and compare states, then a new cluster is written or a
// full table reported, or a join divides one quotient bit a cycle and writes back.
// Throughput: one word at a time; the scan of up to 32 clusters sets the worst case.
// Reset (rst_n low, synchronous): empty table, threshold 1000, no pending result.
`default_nettype none
`include "leader_color_clustering_halfbrite_unit_defines.svh"
module leader_color_clustering_halfbrite_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  lcch_in_if.sink          in_ch,
  lcch_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  localparam logic [lcch_pkg::THR_W-1:0] THR_RESET = 18'd1000;

  logic [lcch_pkg::THR_W-1:0] thr_r;
  lcch_pkg::ctl_t  ctl;
  lcch_pkg::stat_t stat;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {14'd0, thr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == 1'b0) begin
      thr_r <= cfg_pwdata[lcch_pkg::THR_W-1:0];
    end
  end

  lcch_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  lcch_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .stat      (stat),
    .thr       (thr_r),
    .in_cmd    (in_ch.cmd),
    .in_red    (in_ch.red),
    .in_green  (in_ch.green),
    .in_blue   (in_ch.blue),
    .o_id      (out_ch.cluster_id),
    .o_outcome (out_ch.outcome),
    .o_red     (out_ch.mean_red),
    .o_green   (out_ch.mean_green),
    .o_blue    (out_ch.mean_blue)
  );

  `LCCH_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  `LCCH_ASSERT(a_outcome_legal, out_ch.valid |-> out_ch.outcome <= lcch_pkg::OC_CLEAR)
  `LCCH_ASSERT(a_zero_means, (out_ch.valid && (out_ch.outcome == lcch_pkg::OC_FULL ||
    out_ch.outcome == lcch_pkg::OC_CLEAR)) |-> (out_ch.mean_red == '0 &&
    out_ch.cluster_id == '0))
endmodule
`default_nettype wire

// ----- rtl/lcch_ram.sv -----
`default_nettype none
module lcch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/lcch_dp.sv -----
`default_nettype none
module lcch_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire lcch_pkg::ctl_t               ctl,
  output lcch_pkg::stat_t                   stat,
  input  wire logic [lcch_pkg::THR_W-1:0]   thr,
  input  wire logic                         in_cmd,
  input  wire logic [lcch_pkg::COL_W-1:0]   in_red,
  input  wire logic [lcch_pkg::COL_W-1:0]   in_green,
  input  wire logic [lcch_pkg::COL_W-1:0]   in_blue,
  output logic [lcch_pkg::IDX_W-1:0]        o_id,
  output logic [2:0]                        o_outcome,
  output logic [lcch_pkg::MEAN_W-1:0]       o_red,
  output logic [lcch_pkg::MEAN_W-1:0]       o_green,
  output logic [lcch_pkg::MEAN_W-1:0]       o_blue
);
  localparam int MW = lcch_pkg::MEAN_W;
  localparam int CW = lcch_pkg::COL_W;

  logic                         cmd_r;
  logic [CW-1:0]                col_r [3];
  logic [lcch_pkg::IDX_W-1:0]   k_r;
  logic [lcch_pkg::TOT_W-1:0]   total_r;
  logic                         hb_r;
  logic [lcch_pkg::SQ_W-1:0]    sqd_r, sqh_r;
  logic [lcch_pkg::ACC_W-1:0]   accd_r, acch_r;
  logic [lcch_pkg::DVD_W-1:0]   dvd_r [3];
  logic [MW:0]                  rem_r [3];
  logic [MW-1:0]                dsr_r;

  lcch_pkg::entry_t ram_q, wr_ent;
  logic [lcch_pkg::ENT_W-1:0] ram_rdata;
  logic                       ram_we;
  logic [lcch_pkg::IDX_W-1:0] ram_waddr;
  logic [MW-1:0]              m_sel, m_ch [3], dd, dh, cd, ch2;
  logic [CW-1:0]              c_sel;
  logic [MW-1:0]              col_q [3];
  logic [MW+lcch_pkg::CNT_W-1:0] prod [3];

  lcch_ram #(.WIDTH(lcch_pkg::ENT_W), .DEPTH(lcch_pkg::MAX_CL)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_ent),
    .raddr (k_r),
    .rdata (ram_rdata)
  );

  assign ram_q   = lcch_pkg::entry_t'(ram_rdata);
  assign m_ch[0] = ram_q.r;
  assign m_ch[1] = ram_q.g;
  assign m_ch[2] = ram_q.b;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      col_q[i] = {1'b0, col_r[i], {lcch_pkg::FRAC{1'b0}}};
      prod[i]  = m_ch[i] * ram_q.cnt;
    end
    case (ctl.ch)
      2'd0:    begin m_sel = m_ch[0]; c_sel = col_r[0]; end
      2'd1:    begin m_sel = m_ch[1]; c_sel = col_r[1]; end
      default: begin m_sel = m_ch[2]; c_sel = col_r[2]; end
    endcase
    cd  = {1'b0, c_sel, {lcch_pkg::FRAC{1'b0}}};
    ch2 = {c_sel, {(lcch_pkg::FRAC + 1){1'b0}}};
    dd  = (cd > m_sel) ? cd - m_sel : m_sel - cd;
    dh  = (ch2 > m_sel) ? ch2 - m_sel : m_sel - ch2;
  end

  assign stat.is_clear   = (cmd_r == lcch_pkg::CMD_CLEAR);
  assign stat.total_zero = (total_r == '0);
  assign stat.full       = (total_r == lcch_pkg::TOT_W'(lcch_pkg::MAX_CL));
  assign stat.last       = ({1'b0, k_r} + 1'b1 == total_r);
  assign stat.match_d    = accd_r <= lcch_pkg::ACC_W'({thr, {(2 * lcch_pkg::FRAC){1'b0}}});
  assign stat.match_h    = acch_r <= lcch_pkg::ACC_W'({thr, {(2 * lcch_pkg::FRAC + 2){1'b0}}});

  // fold writes back the quotients; a new entry starts at the color itself
  always_comb begin
    ram_we    = ctl.wr_fold | (ctl.wr_new & ~stat.full);
    ram_waddr = ctl.wr_new ? total_r[lcch_pkg::IDX_W-1:0] : k_r;
    if (ctl.wr_new) begin
      wr_ent.r   = col_q[0];
      wr_ent.g   = col_q[1];
      wr_ent.b   = col_q[2];
      wr_ent.cnt = lcch_pkg::CNT_W'(1);
      wr_ent.hb  = 1'b0;
    end else begin
      wr_ent.r   = dvd_r[0][MW-1:0];
      wr_ent.g   = dvd_r[1][MW-1:0];
      wr_ent.b   = dvd_r[2][MW-1:0];
      wr_ent.cnt = (!hb_r && ram_q.cnt != lcch_pkg::CNT_MAX) ? ram_q.cnt + 1'b1 : ram_q.cnt;
      wr_ent.hb  = ram_q.hb | hb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (ctl.clear) begin
      total_r <= '0;
    end else if (ctl.wr_new && !stat.full) begin
      total_r <= total_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.item_ld) begin
      cmd_r    <= in_cmd;
      col_r[0] <= in_red;
      col_r[1] <= in_green;
      col_r[2] <= in_blue;
      k_r      <= '0;
    end else if (ctl.k_inc) begin
      k_r <= k_r + 1'b1;
    end else if (ctl.wr_new && !stat.full) begin
      k_r <= total_r[lcch_pkg::IDX_W-1:0];
    end
    if (ctl.sq_en) begin
      sqd_r <= dd * dd;
      sqh_r <= dh * dh;
    end
    if (ctl.acc_clr) begin
      accd_r <= '0;
      acch_r <= '0;
    end else if (ctl.acc_en) begin
      accd_r <= accd_r + lcch_pkg::ACC_W'(sqd_r);
      acch_r <= acch_r + lcch_pkg::ACC_W'(sqh_r);
    end
    if (ctl.hb_set) begin
      hb_r <= ~stat.match_d;
    end
    if (ctl.mul_ld) begin
      dsr_r <= {1'b0, ram_q.cnt} + 1'b1;
      for (int i = 0; i < 3; i++) begin
        dvd_r[i] <= lcch_pkg::DVD_W'(prod[i])
                  + lcch_pkg::DVD_W'(hb_r ? {col_q[i][MW-2:0], 1'b0} : col_q[i]);
        rem_r[i] <= '0;
      end
    end else if (ctl.div_step) begin
      // restoring division, one quotient bit per cycle
      for (int i = 0; i < 3; i++) begin
        logic [MW:0] sh;
        logic        ge;
        sh = {rem_r[i][MW-1:0], dvd_r[i][lcch_pkg::DVD_W-1]};
        ge = sh >= {1'b0, dsr_r};
        rem_r[i] <= ge ? sh - {1'b0, dsr_r} : sh;
        dvd_r[i] <= {dvd_r[i][lcch_pkg::DVD_W-2:0], ge};
      end
    end
    if (ctl.out_ld) begin
      o_outcome <= ctl.outcome;
      case (ctl.outcome)
        lcch_pkg::OC_DIRECT, lcch_pkg::OC_HB: begin
          o_id    <= k_r;
          o_red   <= dvd_r[0][MW-1:0];
          o_green <= dvd_r[1][MW-1:0];
          o_blue  <= dvd_r[2][MW-1:0];
        end
        lcch_pkg::OC_NEW: begin
          o_id    <= k_r;
          o_red   <= col_q[0];
          o_green <= col_q[1];
          o_blue  <= col_q[2];
        end
        default: begin
          o_id    <= '0;
          o_red   <= '0;
          o_green <= '0;
          o_blue  <= '0;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/lcch_ctrl.sv -----
`default_nettype none
module lcch_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire lcch_pkg::stat_t stat,
  output lcch_pkg::ctl_t       ctl
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_SQ   = 4'd3;
  localparam logic [3:0] S_CMP  = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_WR   = 4'd7;
  localparam logic [3:0] S_NEW  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]                  state_r, state_nxt;
  logic [1:0]                  ch_r, ch_nxt;
  logic [lcch_pkg::DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [2:0]                  oc_r, oc_nxt;
  logic                        ov_r, ov_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt   = state_r;
    ch_nxt      = ch_r;
    cnt_nxt     = cnt_r;
    oc_nxt      = oc_r;
    ov_nxt      = ov_r & ~out_ready;
    ctl         = '0;
    ctl.ch      = ch_r;
    ctl.outcome = oc_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.item_ld = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.is_clear) begin
          ctl.clear = 1'b1;
          oc_nxt    = lcch_pkg::OC_CLEAR;
          state_nxt = S_OUT;
        end else if (stat.total_zero) begin
          state_nxt = S_NEW;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        ch_nxt    = '0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        // squares for channel ch, sum of the previous one
        ctl.sq_en   = (ch_r != 2'd3);
        ctl.acc_clr = (ch_r == 2'd0);
        ctl.acc_en  = (ch_r != 2'd0);
        ch_nxt      = ch_r + 1'b1;
        if (ch_r == 2'd3) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.match_d || stat.match_h) begin
          ctl.hb_set = 1'b1;
          oc_nxt     = stat.match_d ? lcch_pkg::OC_DIRECT : lcch_pkg::OC_HB;
          state_nxt  = S_MUL;
        end else if (stat.last) begin
          state_nxt = S_NEW;
        end else begin
          ctl.k_inc = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_MUL: begin
        ctl.mul_ld = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == lcch_pkg::DIV_LAST) begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        ctl.wr_fold = 1'b1;
        state_nxt   = S_OUT;
      end
      S_NEW: begin
        ctl.wr_new = 1'b1;
        oc_nxt     = stat.full ? lcch_pkg::OC_FULL : lcch_pkg::OC_NEW;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || out_ready) begin
          ctl.out_ld = 1'b1;
          ov_nxt     = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      ch_r    <= '0;
      cnt_r   <= '0;
      oc_r    <= lcch_pkg::OC_DIRECT;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      ch_r    <= ch_nxt;
      cnt_r   <= cnt_nxt;
      oc_r    <= oc_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- tb/leader_color_clustering_halfbrite_unit_tb.sv -----
`default_nettype none
module leader_color_clustering_halfbrite_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                       cmd;
    logic [lcch_pkg::COL_W-1:0] red;
    logic [lcch_pkg::COL_W-1:0] green;
    logic [lcch_pkg::COL_W-1:0] blue;
  } color_word_t;

  typedef struct packed {
    logic [lcch_pkg::IDX_W-1:0]  cluster_id;
    logic [2:0]                  outcome;
    logic [lcch_pkg::MEAN_W-1:0] mean_red;
    logic [lcch_pkg::MEAN_W-1:0] mean_green;
    logic [lcch_pkg::MEAN_W-1:0] mean_blue;
  } cluster_word_t;

  localparam logic [2:0] THR_ADDR = 3'd0;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  lcch_in_if in_ch();
  lcch_out_if out_ch();

  leader_color_clustering_halfbrite_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [lcch_pkg::THR_W-1:0]  thr_q;
  int unsigned                 live_clusters;
  logic [lcch_pkg::MEAN_W-1:0] red_mean [lcch_pkg::MAX_CL];
  logic [lcch_pkg::MEAN_W-1:0] green_mean [lcch_pkg::MAX_CL];
  logic [lcch_pkg::MEAN_W-1:0] blue_mean [lcch_pkg::MAX_CL];
  logic [lcch_pkg::CNT_W-1:0]  member_cnt [lcch_pkg::MAX_CL];

  color_word_t   pending_colors[$];
  cluster_word_t expected_clusters[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_sender = 1'b0;

  function automatic logic [63:0] sq_distance(int k, color_word_t c, int sh);
    logic [63:0] cr, cg, cb, dr, dg, db;
    cr = 64'(c.red) << sh;
    cg = 64'(c.green) << sh;
    cb = 64'(c.blue) << sh;
    dr = cr > red_mean[k] ? cr - red_mean[k] : red_mean[k] - cr;
    dg = cg > green_mean[k] ? cg - green_mean[k] : green_mean[k] - cg;
    db = cb > blue_mean[k] ? cb - blue_mean[k] : blue_mean[k] - cb;
    return dr * dr + dg * dg + db * db;
  endfunction

  function automatic logic [lcch_pkg::MEAN_W-1:0] fold(logic [lcch_pkg::MEAN_W-1:0] m,
                                                       logic [lcch_pkg::CNT_W-1:0] n,
                                                       logic [63:0] add);
    logic [63:0] q;
    q = (64'(m) * 64'(n) + add) / (64'(n) + 64'd1);
    return q[lcch_pkg::MEAN_W-1:0];
  endfunction

  function automatic cluster_word_t classify_color(color_word_t c);
    cluster_word_t r;
    int sh;
    r = '0;
    if (c.cmd == lcch_pkg::CMD_CLEAR) begin
      live_clusters = 0;
      r.outcome = lcch_pkg::OC_CLEAR;
      return r;
    end
    for (int k = 0; k < live_clusters; k++) begin
      for (int pass = 0; pass < 2; pass++) begin
        sh = lcch_pkg::FRAC + pass;
        if (sq_distance(k, c, sh) <= (64'(thr_q) << (2 * sh))) begin
          red_mean[k] = fold(red_mean[k], member_cnt[k], 64'(c.red) << sh);
          green_mean[k] = fold(green_mean[k], member_cnt[k], 64'(c.green) << sh);
          blue_mean[k] = fold(blue_mean[k], member_cnt[k], 64'(c.blue) << sh);
          if (pass == 0 && member_cnt[k] != lcch_pkg::CNT_MAX) member_cnt[k]++;
          r.outcome = pass == 0 ? lcch_pkg::OC_DIRECT : lcch_pkg::OC_HB;
          r.cluster_id = k[lcch_pkg::IDX_W-1:0];
          r.mean_red = red_mean[k];
          r.mean_green = green_mean[k];
          r.mean_blue = blue_mean[k];
          return r;
        end
      end
    end
    if (live_clusters >= lcch_pkg::MAX_CL) begin
      r.outcome = lcch_pkg::OC_FULL;
      return r;
    end
    red_mean[live_clusters] = lcch_pkg::MEAN_W'(c.red) << lcch_pkg::FRAC;
    green_mean[live_clusters] = lcch_pkg::MEAN_W'(c.green) << lcch_pkg::FRAC;
    blue_mean[live_clusters] = lcch_pkg::MEAN_W'(c.blue) << lcch_pkg::FRAC;
    member_cnt[live_clusters] = 1;
    r.outcome = lcch_pkg::OC_NEW;
    r.cluster_id = live_clusters[lcch_pkg::IDX_W-1:0];
    r.mean_red = red_mean[live_clusters];
    r.mean_green = green_mean[live_clusters];
    r.mean_blue = blue_mean[live_clusters];
    live_clusters++;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver; with hold_sender set, each word waits until every result is back
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold word
    end else if (send_gap > 0) begin
      in_ch.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_colors.size() > 0 &&
                 !(hold_sender && expected_clusters.size() > 0)) begin
      color_word_t c;
      cluster_word_t e;
      c = pending_colors.pop_front();
      in_ch.valid <= 1'b1;
      in_ch.cmd <= c.cmd;
      in_ch.red <= c.red;
      in_ch.green <= c.green;
      in_ch.blue <= c.blue;
      e = classify_color(c);
      expected_clusters = {expected_clusters, e};
      send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // monitor
  int recv_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        cluster_word_t w;
        w = expected_clusters.size() > 0 ? expected_clusters.pop_front() : 'x;
        if ($isunknown(w)) begin
          report_mismatch("unexpected word, outcome", out_ch.outcome, -1);
        end else begin
          if (out_ch.cluster_id !== w.cluster_id)
            report_mismatch("cluster_id", out_ch.cluster_id, w.cluster_id);
          if (out_ch.outcome !== w.outcome)
            report_mismatch("outcome", out_ch.outcome, w.outcome);
          if (out_ch.mean_red !== w.mean_red)
            report_mismatch("mean_red", out_ch.mean_red, w.mean_red);
          if (out_ch.mean_green !== w.mean_green)
            report_mismatch("mean_green", out_ch.mean_green, w.mean_green);
          if (out_ch.mean_blue !== w.mean_blue)
            report_mismatch("mean_blue", out_ch.mean_blue, w.mean_blue);
        end
        recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      end
      if (recv_gap > 0) begin
        out_ch.ready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_color(bit cmd, int r, int g, int b);
    color_word_t c;
    c.cmd = cmd;
    c.red = r[7:0];
    c.green = g[7:0];
    c.blue = b[7:0];
    pending_colors = {pending_colors, c};
  endtask

  task automatic drain();
    while (pending_colors.size() > 0 || expected_clusters.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (260) @(posedge clk);
  endtask

  task automatic write_threshold(logic [31:0] v);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= THR_ADDR;
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    thr_q = v[lcch_pkg::THR_W-1:0];
  endtask

  // random phase: mostly colors near a few seeds so joins of both kinds happen
  task automatic random_phase(int count);
    int seed_r, seed_g, seed_b, sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        push_color(1'b1, $urandom, $urandom, $urandom);
      end else if (sel < 30) begin
        push_color(1'b0, $urandom, $urandom, $urandom);
      end else begin
        seed_r = ($urandom_range(0, 7) * 36);
        seed_g = ($urandom_range(0, 7) * 36);
        seed_b = ($urandom_range(0, 7) * 36);
        if (sel < 55) begin
          seed_r = seed_r / 2;
          seed_g = seed_g / 2;
          seed_b = seed_b / 2;
        end
        push_color(1'b0, seed_r + $urandom_range(0, 12), seed_g + $urandom_range(0, 12),
                   seed_b + $urandom_range(0, 12));
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = 1'b0;
    in_ch.red = '0;
    in_ch.green = '0;
    in_ch.blue = '0;
    out_ch.ready = 1'b0;
    thr_q = 18'd1000;
    live_clusters = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, half-bright, clear
    push_color(1'b0, 0, 0, 0);
    push_color(1'b0, 255, 255, 255);
    push_color(1'b0, 254, 255, 250);
    push_color(1'b0, 128, 128, 128);
    push_color(1'b0, 64, 64, 64);
    push_color(1'b0, 200, 10, 100);
    push_color(1'b0, 100, 5, 50);
    push_color(1'b0, 255, 0, 255);
    push_color(1'b0, 0, 255, 0);
    push_color(1'b1, 255, 255, 255);
    push_color(1'b0, 170, 85, 170);
    drain();

    // fill the table to force drops, one word in flight at a time
    write_threshold(32'd0);
    hold_sender = 1'b1;
    for (int i = 0; i < 34; i++) push_color(1'b0, i * 7, 255 - i * 7, i);
    drain();
    hold_sender = 1'b0;
    push_color(1'b1, 0, 0, 0);
    drain();

    write_threshold(32'h3FFFF);
    random_phase(150);
    push_color(1'b1, 0, 0, 0);
    drain();
    write_threshold(32'd1000);
    random_phase(600);
    drain();
    write_threshold(32'd300);
    random_phase(450);
    drain();
    write_threshold($urandom_range(0, 4000));
    random_phase(350);
    drain();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/lcch_pkg.sv
rtl/lcch_if.sv
rtl/lcch_ram.sv
rtl/lcch_dp.sv
rtl/lcch_ctrl.sv
rtl/leader_color_clustering_halfbrite_unit.sv
tb/leader_color_clustering_halfbrite_unit_tb.sv
